// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the airborne detector.
// Each macro samples on posedge clk and is disabled while rst is high.
// With SYNTH defined, every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_IMPLIES_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/ffad_pkg.sv =====
// Package of the airborne detector: register indexes, reset values and
// the structs passed between the detector modules. No dependencies.
package ffad_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALPHA_ACCEL    = 3'd0,
    REG_ALPHA_RATE     = 3'd1,
    REG_FREEFALL_UPPER = 3'd2,
    REG_FREEFALL_LOWER = 3'd3,
    REG_SHOCK_LIMIT    = 3'd4,
    REG_LANDING_LOWER  = 3'd5,
    REG_LANDING_UPPER  = 3'd6,
    REG_TAKEOFF_COUNT  = 3'd7
  } reg_index_t;

  localparam logic [15:0]        ALPHA_ACCEL_RESET    = 16'd19661;
  localparam logic [15:0]        ALPHA_RATE_RESET     = 16'd13107;
  localparam logic signed [15:0] FREEFALL_UPPER_RESET = 16'sd1638;
  localparam logic signed [15:0] FREEFALL_LOWER_RESET = -16'sd1638;
  localparam logic [16:0]        SHOCK_LIMIT_RESET    = 17'd5600;
  localparam logic signed [15:0] LANDING_LOWER_RESET  = 16'sd3277;
  localparam logic signed [15:0] LANDING_UPPER_RESET  = 16'sd4915;
  localparam logic [3:0]         TAKEOFF_COUNT_RESET  = 4'd5;

  localparam logic [3:0]         LANDING_CONFIRM      = 4'd10;
  localparam logic signed [15:0] ACCEL_LOWPASS_RESET  = 16'sd4096;

  typedef struct packed {
    logic [15:0]        alpha_accel;
    logic [15:0]        alpha_rate;
    logic signed [15:0] freefall_upper;
    logic signed [15:0] freefall_lower;
    logic [16:0]        shock_limit;
    logic signed [15:0] landing_lower;
    logic signed [15:0] landing_upper;
    logic [3:0]         takeoff_count;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] accel_vertical;
    logic signed [15:0] rate_pitch;
    logic signed [15:0] rate_roll;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] accel_lowpass;
    logic [16:0]        rate_lowpass;
    logic [3:0]         takeoff_counter;
    logic [3:0]         landing_counter;
    logic               airborne_latch;
  } state_t;

endpackage

// ===== hw/rtl/ffad_if.sv =====
// Channel interfaces of the airborne detector: IMU samples, results and
// configuration writes. Depends on ffad_pkg for widths.
interface ffad_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_vertical;
  logic signed [15:0] rate_pitch;
  logic signed [15:0] rate_roll;
  modport source (output valid, accel_vertical, rate_pitch, rate_roll, input ready);
  modport sink (input valid, accel_vertical, rate_pitch, rate_roll, output ready);
endinterface

interface ffad_result_if;
  logic               valid;
  logic               ready;
  logic               airborne;
  logic signed [15:0] accel_filtered;
  logic [16:0]        rate_filtered;
  modport source (output valid, airborne, accel_filtered, rate_filtered, input ready);
  modport sink (input valid, airborne, accel_filtered, rate_filtered, output ready);
endinterface

interface ffad_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ffad_pkg::CFG_INDEX_W-1:0] index;
  logic [ffad_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/freefall_airborne_detector.sv =====
// Top level of the free-fall and airborne detector.
// Depends on ffad_pkg, the ffad interfaces, ffad_regs, ffad_core and
// assert_macros.svh.
//
// The samples channel takes one IMU sample per request: vertical
// acceleration (Q3.12 g) and pitch and roll rates (1/16 deg/s). The
// results channel returns one request per sample with the airborne flag
// and both filtered values. The cfg channel writes one register per
// request and is always ready; write it only while no sample is in flight.
// A sample is held in an input register, then filters and debounce logic
// update the detector state and the result register once the result
// register is free or taken by the receiver. One sample is accepted every
// cycle while the receiver keeps taking results; the feedback through the
// filter multipliers and counters is combinational.
// Reset restores the register defaults, sets the acceleration filter to
// one g, clears the rate filter and counters and marks the block grounded.
// When the receiver stalls, the result register holds; an empty input
// register still takes one more sample before samples.ready falls.
module freefall_airborne_detector (
  input  logic         clk,
  input  logic         rst,
  ffad_sample_if.sink  samples,
  ffad_result_if.source results,
  ffad_cfg_if.sink     cfg
);

  `include "assert_macros.svh"

  ffad_pkg::cfg_t    regs;
  ffad_pkg::sample_t s1_sample;
  ffad_pkg::state_t  state;
  ffad_pkg::state_t  state_next;

  logic s1_valid;
  logic res_valid;
  logic res_airborne;
  logic signed [15:0] res_accel;
  logic [16:0]        res_rate;

  logic advance;
  logic step;
  logic in_ready;

  ffad_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ffad_core u_core (
    .regs       (regs),
    .sample     (s1_sample),
    .state      (state),
    .state_next (state_next)
  );

  assign advance  = !res_valid || results.ready;
  assign step     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  assign samples.ready          = in_ready;
  assign results.valid          = res_valid;
  assign results.airborne       = res_airborne;
  assign results.accel_filtered = res_accel;
  assign results.rate_filtered  = res_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid                    <= 1'b0;
      res_valid                   <= 1'b0;
      state.accel_lowpass         <= ffad_pkg::ACCEL_LOWPASS_RESET;
      state.rate_lowpass          <= 17'd0;
      state.takeoff_counter       <= 4'd0;
      state.landing_counter       <= 4'd0;
      state.airborne_latch        <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= samples.valid;
      end
      if (advance) begin
        res_valid <= s1_valid;
      end
      if (step) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && in_ready) begin
      s1_sample.accel_vertical <= samples.accel_vertical;
      s1_sample.rate_pitch     <= samples.rate_pitch;
      s1_sample.rate_roll      <= samples.rate_roll;
    end
    if (step) begin
      res_airborne <= state_next.airborne_latch;
      res_accel    <= state_next.accel_lowpass;
      res_rate     <= state_next.rate_lowpass;
    end
  end

  `ASSERT_IMPLIES(a_grounded_no_landing, !state.airborne_latch, state.landing_counter == 4'd0)
  `ASSERT_IMPLIES(a_airborne_no_takeoff, state.airborne_latch, state.takeoff_counter == 4'd0)
  `ASSERT_HOLDS(a_landing_below_confirm, state.landing_counter < ffad_pkg::LANDING_CONFIRM)
  `ASSERT_IMPLIES_NEXT(a_latch_moves_on_step, !step, $stable(state.airborne_latch))

endmodule

// ===== hw/rtl/ffad_regs.sv =====
// Configuration register file of the airborne detector.
// Depends on ffad_pkg and the ffad_cfg_if interface.
module ffad_regs (
  input  logic           clk,
  input  logic           rst,
  ffad_cfg_if.sink       cfg,
  output ffad_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.alpha_accel    <= ffad_pkg::ALPHA_ACCEL_RESET;
      regs.alpha_rate     <= ffad_pkg::ALPHA_RATE_RESET;
      regs.freefall_upper <= ffad_pkg::FREEFALL_UPPER_RESET;
      regs.freefall_lower <= ffad_pkg::FREEFALL_LOWER_RESET;
      regs.shock_limit    <= ffad_pkg::SHOCK_LIMIT_RESET;
      regs.landing_lower  <= ffad_pkg::LANDING_LOWER_RESET;
      regs.landing_upper  <= ffad_pkg::LANDING_UPPER_RESET;
      regs.takeoff_count  <= ffad_pkg::TAKEOFF_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (ffad_pkg::reg_index_t'(cfg.index))
        ffad_pkg::REG_ALPHA_ACCEL:    regs.alpha_accel    <= cfg.data[15:0];
        ffad_pkg::REG_ALPHA_RATE:     regs.alpha_rate     <= cfg.data[15:0];
        ffad_pkg::REG_FREEFALL_UPPER: regs.freefall_upper <= $signed(cfg.data[15:0]);
        ffad_pkg::REG_FREEFALL_LOWER: regs.freefall_lower <= $signed(cfg.data[15:0]);
        ffad_pkg::REG_SHOCK_LIMIT:    regs.shock_limit    <= cfg.data[16:0];
        ffad_pkg::REG_LANDING_LOWER:  regs.landing_lower  <= $signed(cfg.data[15:0]);
        ffad_pkg::REG_LANDING_UPPER:  regs.landing_upper  <= $signed(cfg.data[15:0]);
        ffad_pkg::REG_TAKEOFF_COUNT:  regs.takeoff_count  <= cfg.data[3:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ffad_core.sv =====
// Per-sample update of the airborne detector: both low-pass filters and
// the take-off and landing debounce counters. Depends on ffad_pkg.
module ffad_core (
  input  ffad_pkg::cfg_t    regs,
  input  ffad_pkg::sample_t sample,
  input  ffad_pkg::state_t  state,
  output ffad_pkg::state_t  state_next
);

  // Each filter is lp + floor(alpha * (x - lp) / 2^16), which equals the
  // weighted mix of x and lp, with a single multiplier.
  logic signed [16:0] accel_diff;
  logic signed [33:0] accel_prod;
  logic signed [17:0] accel_sum;
  logic signed [15:0] accel_new;

  logic signed [16:0] pitch_ext;
  logic signed [16:0] roll_ext;
  logic [16:0]        pitch_abs;
  logic [16:0]        roll_abs;
  logic [16:0]        rate_sum_abs;
  logic signed [17:0] rate_diff;
  logic signed [34:0] rate_prod;
  logic signed [18:0] rate_sum;
  logic [16:0]        rate_new;

  logic freefall;
  logic calm;
  logic grounded;
  logic [3:0] takeoff_inc;
  logic [3:0] landing_inc;

  always_comb begin
    accel_diff = 17'(sample.accel_vertical) - 17'(state.accel_lowpass);
    accel_prod = $signed({1'b0, regs.alpha_accel}) * accel_diff;
    accel_sum  = 18'(state.accel_lowpass) + $signed(accel_prod[33:16]);
    accel_new  = accel_sum[15:0];

    pitch_ext    = 17'(sample.rate_pitch);
    roll_ext     = 17'(sample.rate_roll);
    pitch_abs    = pitch_ext[16] ? 17'(-pitch_ext) : 17'(pitch_ext);
    roll_abs     = roll_ext[16] ? 17'(-roll_ext) : 17'(roll_ext);
    rate_sum_abs = pitch_abs + roll_abs;
    rate_diff    = $signed({1'b0, rate_sum_abs}) - $signed({1'b0, state.rate_lowpass});
    rate_prod    = $signed({1'b0, regs.alpha_rate}) * rate_diff;
    rate_sum     = $signed({2'b00, state.rate_lowpass}) + $signed(rate_prod[34:16]);
    rate_new     = rate_sum[16:0];

    freefall = (accel_new < regs.freefall_upper) && (accel_new > regs.freefall_lower);
    calm     = rate_new < regs.shock_limit;
    grounded = (accel_new > regs.landing_lower) && (accel_new < regs.landing_upper);

    takeoff_inc = state.takeoff_counter + 4'd1;
    landing_inc = state.landing_counter + 4'd1;

    state_next               = state;
    state_next.accel_lowpass = accel_new;
    state_next.rate_lowpass  = rate_new;

    if (!state.airborne_latch) begin
      if (freefall && calm) begin
        state_next.landing_counter = 4'd0;
        if (takeoff_inc >= regs.takeoff_count) begin
          state_next.airborne_latch  = 1'b1;
          state_next.takeoff_counter = 4'd0;
        end else begin
          state_next.takeoff_counter = takeoff_inc;
        end
      end else begin
        state_next.takeoff_counter = 4'd0;
      end
    end else begin
      if (grounded) begin
        state_next.takeoff_counter = 4'd0;
        if (landing_inc >= ffad_pkg::LANDING_CONFIRM) begin
          state_next.airborne_latch  = 1'b0;
          state_next.landing_counter = 4'd0;
        end else begin
          state_next.landing_counter = landing_inc;
        end
      end else begin
        state_next.landing_counter = 4'd0;
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the free-fall and airborne detector.
// Needs ffad_pkg and the ffad channel interfaces; a local copy of the filters and
// debounce counters predicts each result, which is compared as it leaves the block.
module tb_top;
  import ffad_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic               airborne;
    logic signed [15:0] accel_filtered;
    logic [16:0]        rate_filtered;
  } detector_result_t;

  logic clk;
  logic rst;

  cfg_t             model_cfg;
  state_t           model_state;
  detector_result_t expected_q[$];

  int mismatches = 0;
  int samples_sent = 0;
  int send_gap_pct = 0;
  int sink_stall_pct = 0;
  int idle_cycles = 0;

  ffad_sample_if sample_ch();
  ffad_result_if result_ch();
  ffad_cfg_if    cfg_ch();

  freefall_airborne_detector u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic int jitter(int spread);
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic void advance_detector(logic signed [15:0] accel, logic signed [15:0] pitch,
                                           logic signed [15:0] roll);
    longint           accel_mix;
    longint           rate_mix;
    int               rate_sum;
    logic             falling;
    logic             calm;
    logic             grounded;
    detector_result_t res;
    accel_mix = longint'(model_cfg.alpha_accel) * longint'(accel)
              + longint'(65536 - int'(model_cfg.alpha_accel))
              * longint'(model_state.accel_lowpass);
    model_state.accel_lowpass = 16'(accel_mix >>> 16);
    rate_sum = (pitch < 0 ? -int'(pitch) : int'(pitch)) + (roll < 0 ? -int'(roll) : int'(roll));
    rate_mix = longint'(model_cfg.alpha_rate) * longint'(rate_sum)
             + longint'(65536 - int'(model_cfg.alpha_rate)) * longint'(model_state.rate_lowpass);
    model_state.rate_lowpass = 17'(rate_mix >>> 16);
    falling = model_state.accel_lowpass < model_cfg.freefall_upper
           && model_state.accel_lowpass > model_cfg.freefall_lower;
    calm = model_state.rate_lowpass < model_cfg.shock_limit;
    grounded = model_state.accel_lowpass > model_cfg.landing_lower
            && model_state.accel_lowpass < model_cfg.landing_upper;
    if (!model_state.airborne_latch) begin
      if (falling && calm) begin
        model_state.takeoff_counter = model_state.takeoff_counter + 4'd1;
        model_state.landing_counter = 4'd0;
        if (model_state.takeoff_counter >= model_cfg.takeoff_count) begin
          model_state.airborne_latch  = 1'b1;
          model_state.takeoff_counter = 4'd0;
        end
      end else begin
        model_state.takeoff_counter = 4'd0;
      end
    end else begin
      if (grounded) begin
        model_state.landing_counter = model_state.landing_counter + 4'd1;
        model_state.takeoff_counter = 4'd0;
        if (model_state.landing_counter >= LANDING_CONFIRM) begin
          model_state.airborne_latch  = 1'b0;
          model_state.landing_counter = 4'd0;
        end
      end else begin
        model_state.landing_counter = 4'd0;
      end
    end
    res.airborne       = model_state.airborne_latch;
    res.accel_filtered = model_state.accel_lowpass;
    res.rate_filtered  = model_state.rate_lowpass;
    expected_q.push_back(res);
  endfunction

  task automatic send_sample(input logic signed [15:0] accel, input logic signed [15:0] pitch,
                             input logic signed [15:0] roll);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.accel_vertical <= accel;
    sample_ch.rate_pitch     <= pitch;
    sample_ch.rate_roll      <= roll;
    do @(posedge clk); while (!sample_ch.ready);
    advance_detector(accel, pitch, roll);
    samples_sent++;
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Writes every register in index order once the block has gone idle.
  task automatic apply_config(input cfg_t c);
    reg_index_t  idx;
    logic [16:0] value;
    drain_pipeline();
    for (int i = 0; i < 8; i++) begin
      idx = reg_index_t'(i);
      case (idx)
        REG_ALPHA_ACCEL:    value = {1'b0, c.alpha_accel};
        REG_ALPHA_RATE:     value = {1'b0, c.alpha_rate};
        REG_FREEFALL_UPPER: value = {1'b0, c.freefall_upper};
        REG_FREEFALL_LOWER: value = {1'b0, c.freefall_lower};
        REG_SHOCK_LIMIT:    value = c.shock_limit;
        REG_LANDING_LOWER:  value = {1'b0, c.landing_lower};
        REG_LANDING_UPPER:  value = {1'b0, c.landing_upper};
        default:            value = {13'd0, c.takeoff_count};
      endcase
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= value;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    model_cfg = c;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_pressure(input int mode);
    case (mode)
      0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
      1: begin send_gap_pct = 75; sink_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  sink_stall_pct = 75; end
      default: begin send_gap_pct = 15; sink_stall_pct = 15; end
    endcase
  endtask

  function automatic logic [15:0] pick_alpha();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(6000, 65535));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_bound(int nominal, int spread);
    case ($urandom_range(0, 15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom);
      default: return clip16(nominal + jitter(spread));
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.alpha_accel    = pick_alpha();
    c.alpha_rate     = pick_alpha();
    c.freefall_upper = pick_bound(1638, 800);
    c.freefall_lower = pick_bound(-1638, 800);
    case ($urandom_range(0, 9))
      0: c.shock_limit = 17'd0;
      1: c.shock_limit = 17'h1FFFF;
      2: c.shock_limit = 17'($urandom);
      default: c.shock_limit = 17'($urandom_range(2000, 12000));
    endcase
    c.landing_lower  = pick_bound(3277, 600);
    c.landing_upper  = pick_bound(4915, 600);
    c.takeoff_count  = 4'($urandom_range(0, 15));
    return c;
  endfunction

  // One in twelve requests is pure noise over the full field range.
  task automatic emit(input int accel_center, input int accel_spread, input int rate_spread);
    if ($urandom_range(0, 11) == 0) begin
      send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_sample(clip16(accel_center + jitter(accel_spread)), clip16(jitter(rate_spread)),
                  clip16(jitter(rate_spread)));
    end
  endtask

  task automatic fly_episode();
    repeat ($urandom_range(0, 8)) emit(4096, 500, 1500);
    repeat ($urandom_range(0, 22)) emit(0, 900, 250);
    repeat ($urandom_range(0, 24)) emit(4096, 700, 1500);
  endtask

  task automatic test_reset_state();
    repeat (2) send_sample(16'sd4096, 16'sd0, 16'sd0);
  endtask

  task automatic test_field_extremes();
    cfg_t c;
    c = model_cfg;
    c.alpha_accel = 16'hFFFF;
    c.alpha_rate  = 16'hFFFF;
    apply_config(c);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sd0, -16'sd1, 16'sd1);
    send_sample(16'sh8000, 16'sd0, 16'sd0);
    c.alpha_accel = 16'd0;
    c.alpha_rate  = 16'd0;
    apply_config(c);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
  endtask

  task automatic test_instant_takeoff_and_landing();
    cfg_t c;
    c = '{ALPHA_ACCEL_RESET, ALPHA_RATE_RESET, FREEFALL_UPPER_RESET, FREEFALL_LOWER_RESET,
          SHOCK_LIMIT_RESET, LANDING_LOWER_RESET, LANDING_UPPER_RESET, 4'd0};
    c.alpha_accel = 16'hFFFF;
    c.alpha_rate  = 16'hFFFF;
    apply_config(c);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    repeat (3) send_sample(16'sd4096, 16'sd40, -16'sd40);
    send_sample(16'sd0, 16'sd40, -16'sd40);
    repeat (10) send_sample(16'sd4096, -16'sd40, 16'sd40);
  endtask

  task automatic test_empty_bands();
    cfg_t c;
    c = model_cfg;
    c.freefall_upper = 16'sd0;
    c.freefall_lower = 16'sd0;
    c.shock_limit    = 17'h1FFFF;
    c.takeoff_count  = 4'd1;
    apply_config(c);
    repeat (2) send_sample(16'sd0, 16'sd0, 16'sd0);
    c.freefall_upper = 16'sd100;
    c.freefall_lower = -16'sd100;
    c.landing_lower  = 16'sd5000;
    c.landing_upper  = 16'sd3000;
    apply_config(c);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd4096, 16'sd0, 16'sd0);
  endtask

  task automatic test_random_flights();
    int target;
    for (int phase = 0; phase < 8; phase++) begin
      apply_config(random_config());
      set_pressure(phase % 4);
      target = samples_sent + 50;
      while (samples_sent < target) fly_episode();
    end
  endtask

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_results
    detector_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got airborne=%0d accel=%0d rate=%0d", $time,
                 result_ch.airborne, result_ch.accel_filtered, result_ch.rate_filtered);
      end else begin
        want = expected_q.pop_front();
        if (result_ch.airborne !== want.airborne) begin
          mismatches++;
          $display("%0t: airborne expected %0d got %0d", $time, want.airborne,
                   result_ch.airborne);
        end
        if (result_ch.accel_filtered !== want.accel_filtered) begin
          mismatches++;
          $display("%0t: accel_filtered expected %0d got %0d", $time, want.accel_filtered,
                   result_ch.accel_filtered);
        end
        if (result_ch.rate_filtered !== want.rate_filtered) begin
          mismatches++;
          $display("%0t: rate_filtered expected %0d got %0d", $time, want.rate_filtered,
                   result_ch.rate_filtered);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst                      = 1'b1;
    sample_ch.valid          = 1'b0;
    sample_ch.accel_vertical = '0;
    sample_ch.rate_pitch     = '0;
    sample_ch.rate_roll      = '0;
    result_ch.ready          = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = REG_ALPHA_ACCEL;
    cfg_ch.data              = '0;
    model_cfg = '{ALPHA_ACCEL_RESET, ALPHA_RATE_RESET, FREEFALL_UPPER_RESET,
                  FREEFALL_LOWER_RESET, SHOCK_LIMIT_RESET, LANDING_LOWER_RESET,
                  LANDING_UPPER_RESET, TAKEOFF_COUNT_RESET};
    model_state = '{ACCEL_LOWPASS_RESET, 17'd0, 4'd0, 4'd0, 1'b0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_pressure(0);
    test_reset_state();
    test_field_extremes();
    test_instant_takeoff_and_landing();
    test_empty_bands();
    test_random_flights();

    drain_pipeline();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ffad_pkg.sv
hw/rtl/ffad_if.sv
hw/rtl/ffad_regs.sv
hw/rtl/ffad_core.sv
hw/rtl/freefall_airborne_detector.sv
tb/tb_top.sv
